/* design/dlps_pkg.sv */
// Shared types and constants for the dashed line pixel shader.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package dlps_pkg;

  // Pixel coordinate width and the widths that follow from it
  localparam int COORD_BITS = 11;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int DIR_W      = 16;
  localparam int PROD_W     = DIR_W + DIFF_W;
  localparam int SUM_W      = PROD_W + 1;

  // Fixed field widths
  localparam int CH_W      = 8;
  localparam int WGT_W     = 9;
  localparam int EXT_W     = 16;
  localparam int LIM_W     = EXT_W + 8;
  localparam int RAMP_W    = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Full coverage weight and largest dash step exponent
  localparam logic [WGT_W-1:0] WGT_FULL = 9'd256;
  localparam logic [2:0]       STEP_MAX = 3'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_DIR_A        = 3'd2,
    REG_DIR_B        = 3'd3,
    REG_LINE_EXTENT  = 3'd4,
    REG_DASH_PATTERN = 3'd5,
    REG_LINE_WIDTH   = 3'd6,
    REG_LINE_COLOR   = 3'd7
  } cfg_reg_t;

  // Packed color, red in the low byte
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  // Dash pattern register layout
  typedef struct packed {
    logic [7:0] phase;
    logic [7:0] len;
    logic [3:0] step;
  } dash_t;

endpackage

`default_nettype wire

/* design/dlps_proj.sv */
// Projection pipeline: offsets from the origin, four products, along and across sums.
// Uses dlps_pkg for widths and the color type.
`default_nettype none

module dlps_proj (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [dlps_pkg::COORD_BITS-1:0]        pixel_x,
  input  logic [dlps_pkg::COORD_BITS-1:0]        pixel_y,
  input  dlps_pkg::color_t                       dst,
  input  logic [dlps_pkg::COORD_BITS-1:0]        origin_x,
  input  logic [dlps_pkg::COORD_BITS-1:0]        origin_y,
  input  logic signed [dlps_pkg::DIR_W-1:0]      dir_a,
  input  logic signed [dlps_pkg::DIR_W-1:0]      dir_b,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dlps_pkg::SUM_W-1:0]      q,
  output logic [dlps_pkg::SUM_W-1:0]             at,
  output dlps_pkg::color_t                       color
);

  localparam int DIFF_W = dlps_pkg::DIFF_W;
  localparam int PROD_W = dlps_pkg::PROD_W;
  localparam int SUM_W  = dlps_pkg::SUM_W;

  logic                     adv1, adv2, adv3;
  logic                     s1_vld, s2_vld, s3_vld;
  logic signed [DIFF_W-1:0] dx_next, dy_next;
  logic signed [DIFF_W-1:0] s1_dx, s1_dy;
  dlps_pkg::color_t         s1_col, s2_col, s3_col;
  logic signed [PROD_W-1:0] ax_next, by_next, bx_next, ay_next;
  logic signed [PROD_W-1:0] s2_ax, s2_by, s2_bx, s2_ay;
  logic signed [SUM_W-1:0]  q_next, t_pos, t_neg;
  logic [SUM_W-1:0]         at_next;
  logic signed [SUM_W-1:0]  s3_q;
  logic [SUM_W-1:0]         s3_at;

  // A stage advances when it is empty or the next one advances
  assign adv3     = !s3_vld || out_ready;
  assign adv2     = !s2_vld || adv3;
  assign adv1     = !s1_vld || adv2;
  assign in_ready = adv1;

  // Stage 1: signed offsets from the origin
  assign dx_next = $signed({1'b0, pixel_x}) - $signed({1'b0, origin_x});
  assign dy_next = $signed({1'b0, pixel_y}) - $signed({1'b0, origin_y});

  // Stage 2: direction products
  assign ax_next = PROD_W'(dir_a) * PROD_W'(s1_dx);
  assign by_next = PROD_W'(dir_b) * PROD_W'(s1_dy);
  assign bx_next = PROD_W'(dir_b) * PROD_W'(s1_dx);
  assign ay_next = PROD_W'(dir_a) * PROD_W'(s1_dy);

  // Stage 3: along distance and absolute across distance
  assign q_next  = SUM_W'(s2_ax) + SUM_W'(s2_by);
  assign t_pos   = SUM_W'(s2_bx) - SUM_W'(s2_ay);
  assign t_neg   = SUM_W'(s2_ay) - SUM_W'(s2_bx);
  assign at_next = t_pos[SUM_W-1] ? t_neg : t_pos;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      if (adv1) s1_vld <= in_valid;
      if (adv2) s2_vld <= s1_vld;
      if (adv3) s3_vld <= s2_vld;
    end
  end

  // Payload: load only when a valid item moves in, hold otherwise
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_dx  <= dx_next;
      s1_dy  <= dy_next;
      s1_col <= dst;
    end
    if (adv2 && s1_vld) begin
      s2_ax  <= ax_next;
      s2_by  <= by_next;
      s2_bx  <= bx_next;
      s2_ay  <= ay_next;
      s2_col <= s1_col;
    end
    if (adv3 && s2_vld) begin
      s3_q   <= q_next;
      s3_at  <= at_next;
      s3_col <= s2_col;
    end
  end

  assign out_valid = s3_vld;
  assign q         = s3_q;
  assign at        = s3_at;
  assign color     = s3_col;

endmodule

`default_nettype wire

/* design/dlps_cover.sv */
// Coverage stage: span test, dash gate and clamped coverage weight.
// Uses dlps_pkg for widths, the dash layout and the color type.
`default_nettype none

module dlps_cover (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dlps_pkg::SUM_W-1:0]   q,
  input  logic [dlps_pkg::SUM_W-1:0]          at,
  input  dlps_pkg::color_t                    in_color,
  input  logic signed [dlps_pkg::EXT_W-1:0]   line_extent,
  input  dlps_pkg::dash_t                     dash,
  input  logic [7:0]                          line_width,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dlps_pkg::WGT_W-1:0]          w,
  output dlps_pkg::color_t                    out_color
);

  localparam int SUM_W  = dlps_pkg::SUM_W;
  localparam int LIM_W  = dlps_pkg::LIM_W;
  localparam int RAMP_W = dlps_pkg::RAMP_W;
  localparam int WGT_W  = dlps_pkg::WGT_W;

  logic                     adv;
  logic                     enabled;
  logic signed [SUM_W-1:0]  lim;
  logic                     in_span;
  logic [2:0]               step_c;
  logic [7:0]               dmask;
  logic [7:0]               pos;
  logic                     gate;
  logic [RAMP_W-1:0]        ramp;
  logic                     at_below;
  logic [RAMP_W-1:0]        diff;
  logic [WGT_W-1:0]         ramp_w;
  logic [WGT_W-1:0]         w_next;
  logic                     vld;
  logic [WGT_W-1:0]         w_reg;
  dlps_pkg::color_t         col_reg;

  assign adv      = !vld || out_ready;
  assign in_ready = adv;

  // Span: 0 <= q <= extent<<8, drawing only for a positive extent
  assign enabled = !line_extent[dlps_pkg::EXT_W-1] && (line_extent != '0);
  assign lim     = $signed({{(SUM_W-LIM_W){line_extent[dlps_pkg::EXT_W-1]}},
                            line_extent, 8'h00});
  assign in_span = !q[SUM_W-1] && (q <= lim);

  // Dash gate on the pixel index along the line plus phase
  assign step_c = (dash.step > {1'b0, dlps_pkg::STEP_MAX}) ? dlps_pkg::STEP_MAX
                                                           : dash.step[2:0];
  assign dmask  = 8'hFF >> (dlps_pkg::STEP_MAX - step_c);
  assign pos    = (q[15:8] + dash.phase) & dmask;
  assign gate   = (pos <= dash.len);

  // Coverage ramp minus across distance, clamped to 0..256
  assign ramp     = {({1'b0, line_width} + 9'd1), 7'b0};
  assign at_below = (at < SUM_W'(ramp));
  assign diff     = ramp - at[RAMP_W-1:0];
  assign ramp_w   = (diff >= RAMP_W'(dlps_pkg::WGT_FULL)) ? dlps_pkg::WGT_FULL
                                                          : diff[WGT_W-1:0];
  assign w_next   = (enabled && in_span && gate && at_below) ? ramp_w : '0;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  // Weight and color
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      w_reg   <= w_next;
      col_reg <= in_color;
    end
  end

  assign out_valid = vld;
  assign w         = w_reg;
  assign out_color = col_reg;

`ifndef SYNTH
  // A disabled line never yields weight
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && !enabled) |=> (out_valid && w == '0))
    else $error("weight nonzero with non-positive extent");

  // Weight stays within full coverage
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (w <= dlps_pkg::WGT_FULL))
    else $error("weight above full coverage");
`endif

endmodule

`default_nettype wire

/* design/dlps_blend.sv */
// Output stage: blends the line color into the frame pixel and holds the result item.
// Uses dlps_pkg for widths and the color type.
`default_nettype none

module dlps_blend (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dlps_pkg::WGT_W-1:0]       w,
  input  dlps_pkg::color_t                 dst,
  input  dlps_pkg::color_t                 line_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dlps_pkg::CH_W-1:0]        out_red,
  output logic [dlps_pkg::CH_W-1:0]        out_green,
  output logic [dlps_pkg::CH_W-1:0]        out_blue,
  output logic                             covered
);

  localparam int CH_W  = dlps_pkg::CH_W;
  localparam int WGT_W = dlps_pkg::WGT_W;
  localparam int ACC_W = CH_W + WGT_W;

  logic             adv;
  logic             cov_next;
  dlps_pkg::color_t mix_next;
  dlps_pkg::color_t res_next;
  logic             vld;
  dlps_pkg::color_t res;
  logic             cov;

  // (src*w + dst*(256-w)) >> 8
  function automatic logic [CH_W-1:0] mix(input logic [CH_W-1:0] s,
                                          input logic [CH_W-1:0] d,
                                          input logic [WGT_W-1:0] wt);
    logic [ACC_W-1:0] acc;
    acc = ACC_W'(s) * ACC_W'(wt) + ACC_W'(d) * ACC_W'(dlps_pkg::WGT_FULL - wt);
    return acc[2*CH_W-1:CH_W];
  endfunction

  assign adv      = !vld || !out_stall;
  assign in_ready = adv;

  // Blend each channel, pass the pixel through at zero weight
  assign cov_next       = (w != '0);
  assign mix_next.red   = mix(line_color.red,   dst.red,   w);
  assign mix_next.green = mix(line_color.green, dst.green, w);
  assign mix_next.blue  = mix(line_color.blue,  dst.blue,  w);
  assign res_next       = cov_next ? mix_next : dst;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  // Result item
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      res <= res_next;
      cov <= cov_next;
    end
  end

  assign out_valid = vld;
  assign out_red   = res.red;
  assign out_green = res.green;
  assign out_blue  = res.blue;
  assign covered   = cov;

`ifndef SYNTH
  // An uncovered pixel leaves with its own color
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && w == '0) |=>
      (!covered && out_red == $past(dst.red) && out_green == $past(dst.green)
       && out_blue == $past(dst.blue)))
    else $error("uncovered pixel color changed");
`endif

endmodule

`default_nettype wire

/* design/dashed_line_pixel_shader_top.sv */
// Top level of the dashed line pixel shader: configuration registers and the pipeline.
// Uses dlps_pkg and instantiates dlps_proj, dlps_cover and dlps_blend.
`default_nettype none

// Antialiased dashed line shader. Each item is one frame pixel (coordinates and
// current color); each result item is that pixel with the line color blended in by
// its coverage, or unchanged with covered low. The pipeline takes one pixel per
// clock when the output is not stalled and has five register stages: offset
// subtract, four 16x12 signed multipliers, along/across sums, span/dash/coverage
// weight, and six 8x9 blend multipliers feeding the output register. A stall on
// the output backs up stage by stage, and empty stages keep accepting. Write the
// registers only while no pixel is in flight; all of them reset to zero, which
// disables drawing.
module dashed_line_pixel_shader_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlps_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dlps_pkg::COORD_BITS-1:0]     pixel_x,
  input  logic [dlps_pkg::COORD_BITS-1:0]     pixel_y,
  input  logic [dlps_pkg::CH_W-1:0]           dst_red,
  input  logic [dlps_pkg::CH_W-1:0]           dst_green,
  input  logic [dlps_pkg::CH_W-1:0]           dst_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dlps_pkg::CH_W-1:0]           out_red,
  output logic [dlps_pkg::CH_W-1:0]           out_green,
  output logic [dlps_pkg::CH_W-1:0]           out_blue,
  output logic                                covered
);

  localparam int COORD_BITS = dlps_pkg::COORD_BITS;
  localparam int DIR_W      = dlps_pkg::DIR_W;
  localparam int SUM_W      = dlps_pkg::SUM_W;

  logic [COORD_BITS-1:0]             origin_x;
  logic [COORD_BITS-1:0]             origin_y;
  logic signed [DIR_W-1:0]           dir_a;
  logic signed [DIR_W-1:0]           dir_b;
  logic signed [dlps_pkg::EXT_W-1:0] line_extent;
  dlps_pkg::dash_t                   dash_pattern;
  logic [7:0]                        line_width;
  dlps_pkg::color_t                  line_color;

  dlps_pkg::color_t                  dst;
  logic                              proj_ready;
  logic                              proj_valid, cov_ready;
  logic signed [SUM_W-1:0]           proj_q;
  logic [SUM_W-1:0]                  proj_at;
  dlps_pkg::color_t                  proj_col;
  logic                              cov_valid, blend_ready;
  logic [dlps_pkg::WGT_W-1:0]        cov_w;
  dlps_pkg::color_t                  cov_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      dir_a        <= '0;
      dir_b        <= '0;
      line_extent  <= '0;
      dash_pattern <= '0;
      line_width   <= '0;
      line_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dlps_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data[COORD_BITS-1:0];
        dlps_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data[COORD_BITS-1:0];
        dlps_pkg::REG_DIR_A:        dir_a        <= cfg_data[DIR_W-1:0];
        dlps_pkg::REG_DIR_B:        dir_b        <= cfg_data[DIR_W-1:0];
        dlps_pkg::REG_LINE_EXTENT:  line_extent  <= cfg_data[dlps_pkg::EXT_W-1:0];
        dlps_pkg::REG_DASH_PATTERN: dash_pattern <= cfg_data[$bits(dlps_pkg::dash_t)-1:0];
        dlps_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data[7:0];
        dlps_pkg::REG_LINE_COLOR:   line_color   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign dst.red   = dst_red;
  assign dst.green = dst_green;
  assign dst.blue  = dst_blue;
  assign in_stall  = !proj_ready;

  dlps_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (proj_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .dst       (dst),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .dir_a     (dir_a),
    .dir_b     (dir_b),
    .out_valid (proj_valid),
    .out_ready (cov_ready),
    .q         (proj_q),
    .at        (proj_at),
    .color     (proj_col)
  );

  dlps_cover u_cover (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (proj_valid),
    .in_ready    (cov_ready),
    .q           (proj_q),
    .at          (proj_at),
    .in_color    (proj_col),
    .line_extent (line_extent),
    .dash        (dash_pattern),
    .line_width  (line_width),
    .out_valid   (cov_valid),
    .out_ready   (blend_ready),
    .w           (cov_w),
    .out_color   (cov_col)
  );

  dlps_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cov_valid),
    .in_ready   (blend_ready),
    .w          (cov_w),
    .dst        (cov_col),
    .line_color (line_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .covered    (covered)
  );

`ifndef SYNTH
  // Input can only back up behind a result item that waits
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free output stage");
`endif

endmodule

`default_nettype wire
